>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker of the frame sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is low.
`define FAS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define FAS_ASSERT(lbl, prop, msg) \
  `FAS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/fas_pkg.sv
// Types, codes and constants of the frame animation sequencer.
package fas_pkg;

  localparam int TIME_BITS     = 32;
  localparam int MAX_FRAMES    = 256;
  localparam int FRAME_BITS    = 8;
  localparam int COUNT_BITS    = 9;
  localparam int INTERVAL_BITS = 16;
  localparam int DELTA_BITS    = 16;
  localparam int CFG_BITS      = 16;
  localparam int STEP_BITS     = 6;

  localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_LIMIT =
    COUNT_BITS'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_PLAY  = 2'd1,
    REQ_PAUSE = 2'd2,
    REQ_SET   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_PAUSED   = 2'd0,
    MODE_PLAYING  = 2'd1,
    MODE_COOLDOWN = 2'd2,
    MODE_ENDED    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_COUNT    = 2'd1,
    CFG_LOOP     = 2'd2,
    CFG_COOLDOWN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                     start;
    logic [TIME_BITS-1:0]     dividend;
    logic [INTERVAL_BITS-1:0] divisor;
    logic [STEP_BITS-1:0]     steps;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [TIME_BITS-1:0]     quotient;
    logic [INTERVAL_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/core/frame_animation_sequencer.sv
// Frame animation sequencer top level: request decoding, state and result register.
// Each request yields one result. Play, pause, set-frame and ticks outside the playing
// state pass through the execute and emit states, where the result is registered. A tick
// while playing runs the shared one-bit-per-cycle divider for the frame advance; a
// looping overrun adds a 32-step pass for the advance modulo the frame count and a
// 9-step pass for the wrap. A full output register adds the cycles until its result is taken.
// The block takes one request at a time and accepts the next as soon as the previous
// result sits in the output register.
module frame_animation_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // frame_select[7:0], now_ms[39:8], delta_ms[55:40]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // current_frame[7:0]
  output logic [2:0]  m_axis_tuser,  // anim_state[1:0], frame_error[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIVQ = 3'd2;
  localparam logic [2:0] S_DIVM = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam int TB = fas_pkg::TIME_BITS;
  localparam int CB = fas_pkg::COUNT_BITS;
  localparam int FB = fas_pkg::FRAME_BITS;

  logic [2:0]                        state_q, state_d;
  fas_pkg::req_type_e                req_q, req_d;
  logic [FB-1:0]                     sel_q, sel_d;
  logic [TB-1:0]                     now_q, now_d;
  logic [fas_pkg::DELTA_BITS-1:0]    delta_q, delta_d;
  logic [fas_pkg::INTERVAL_BITS-1:0] interval_q, interval_d;
  logic [CB-1:0]                     count_q, count_d;
  logic                              loop_q, loop_d;
  logic [fas_pkg::INTERVAL_BITS-1:0] cooldown_q, cooldown_d;
  fas_pkg::mode_e                    mode_q, mode_d;
  logic [FB-1:0]                     idx_q, idx_d;
  logic [TB-1:0]                     acc_q, acc_d;
  logic [TB-1:0]                     cd_end_q, cd_end_d;
  logic                              was_set_q, was_set_d;
  logic                              err_q, err_d;
  logic                              ovalid_q, ovalid_d;
  logic [FB-1:0]                     ofr_q, ofr_d;
  logic [1:0]                        ostate_q, ostate_d;
  logic                              oerr_q, oerr_d;

  logic [CB-1:0]                     eff_cnt;
  logic [fas_pkg::INTERVAL_BITS-1:0] eff_iv;
  logic [TB:0]                       acc_sum;
  logic [TB-1:0]                     acc_sat;
  logic [TB:0]                       cd_sum;
  logic [TB-1:0]                     cd_sat;
  logic [CB-1:0]                     room;
  logic                              in_range;
  logic                              restart;
  logic [FB-1:0]                     play_idx;
  logic                              play_set;
  logic [CB-1:0]                     wsum;
  logic [TB-1:0]                     quo;
  fas_pkg::div_req_t                 div_req;
  fas_pkg::div_rsp_t                 div_rsp;

  fas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign eff_cnt  = (count_q == '0) ? CB'(1) :
                    ((count_q > fas_pkg::CNT_LIMIT) ? fas_pkg::CNT_LIMIT : count_q);
  assign eff_iv   = (interval_q == '0) ? fas_pkg::INTERVAL_BITS'(1) : interval_q;
  assign acc_sum  = {1'b0, acc_q} + (TB+1)'(delta_q);
  assign acc_sat  = acc_sum[TB] ? fas_pkg::TIME_MAX : acc_sum[TB-1:0];
  assign cd_sum   = {1'b0, now_q} + (TB+1)'(cooldown_q);
  assign cd_sat   = cd_sum[TB] ? fas_pkg::TIME_MAX : cd_sum[TB-1:0];
  assign quo      = div_rsp.quotient;
  assign room     = eff_cnt - {1'b0, idx_q};
  assign in_range = ({1'b0, idx_q} < eff_cnt) && (quo < TB'(room));
  assign restart  = (mode_q == fas_pkg::MODE_ENDED) || (mode_q == fas_pkg::MODE_COOLDOWN);
  assign play_idx = (restart && !was_set_q) ? '0 : idx_q;
  assign play_set = restart ? 1'b0 : was_set_q;
  assign wsum     = {1'b0, idx_q} + {1'b0, div_rsp.remainder[FB-1:0]};

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    sel_d      = sel_q;
    now_d      = now_q;
    delta_d    = delta_q;
    interval_d = interval_q;
    count_d    = count_q;
    loop_d     = loop_q;
    cooldown_d = cooldown_q;
    mode_d     = mode_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    cd_end_d   = cd_end_q;
    was_set_d  = was_set_q;
    err_d      = err_q;
    ovalid_d   = ovalid_q;
    ofr_d      = ofr_q;
    ostate_d   = ostate_q;
    oerr_d     = oerr_q;
    div_req    = '0;

    if (cfg_valid) begin
      unique case (cfg_addr)
        fas_pkg::CFG_INTERVAL: interval_d = cfg_data;
        fas_pkg::CFG_COUNT:    count_d    = cfg_data[CB-1:0];
        fas_pkg::CFG_LOOP:     loop_d     = cfg_data[0];
        fas_pkg::CFG_COOLDOWN: cooldown_d = cfg_data;
      endcase
    end

    if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d   = fas_pkg::req_type_e'(s_axis_tuser);
          sel_d   = s_axis_tdata[7:0];
          now_d   = s_axis_tdata[39:8];
          delta_d = s_axis_tdata[55:40];
          err_d   = 1'b0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        unique case (req_q)
          fas_pkg::REQ_TICK: begin
            if (mode_q == fas_pkg::MODE_PLAYING) begin
              acc_d            = acc_sat;
              div_req.start    = 1'b1;
              div_req.dividend = acc_sat;
              div_req.divisor  = eff_iv;
              div_req.steps    = fas_pkg::STEP_BITS'(TB);
              state_d          = S_DIVQ;
            end else if (mode_q == fas_pkg::MODE_COOLDOWN && now_q >= cd_end_q) begin
              idx_d     = play_idx;
              was_set_d = play_set;
              mode_d    = fas_pkg::MODE_PLAYING;
            end
          end
          fas_pkg::REQ_PLAY: begin
            idx_d     = play_idx;
            was_set_d = play_set;
            mode_d    = fas_pkg::MODE_PLAYING;
          end
          fas_pkg::REQ_PAUSE: begin
            if (mode_q == fas_pkg::MODE_PLAYING || mode_q == fas_pkg::MODE_COOLDOWN) begin
              mode_d = fas_pkg::MODE_PAUSED;
            end
          end
          fas_pkg::REQ_SET: begin
            if ({1'b0, sel_q} >= eff_cnt) begin
              err_d = 1'b1;
            end else begin
              idx_d = sel_q;
              if (restart) begin
                was_set_d = 1'b1;
              end
            end
          end
        endcase
      end
      S_DIVQ: begin
        if (div_rsp.done) begin
          state_d = S_EMIT;
          if (quo != '0) begin
            acc_d = '0;
            if (in_range) begin
              idx_d = idx_q + quo[FB-1:0];
            end else if (loop_q) begin
              cd_end_d         = cd_sat;
              mode_d           = fas_pkg::MODE_COOLDOWN;
              div_req.start    = 1'b1;
              div_req.dividend = quo;
              div_req.divisor  = fas_pkg::INTERVAL_BITS'(eff_cnt);
              div_req.steps    = fas_pkg::STEP_BITS'(TB);
              state_d          = S_DIVM;
            end else begin
              mode_d = fas_pkg::MODE_ENDED;
              idx_d  = FB'(eff_cnt - CB'(1));
            end
          end
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {wsum, {(TB-CB){1'b0}}};
          div_req.divisor  = fas_pkg::INTERVAL_BITS'(eff_cnt);
          div_req.steps    = fas_pkg::STEP_BITS'(CB);
          state_d          = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          idx_d   = div_rsp.remainder[FB-1:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ofr_d    = idx_q;
          ostate_d = mode_q;
          oerr_d   = err_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      interval_q <= fas_pkg::INTERVAL_BITS'(100);
      count_q    <= CB'(1);
      loop_q     <= 1'b1;
      cooldown_q <= '0;
      mode_q     <= fas_pkg::MODE_PAUSED;
      idx_q      <= '0;
      acc_q      <= '0;
      cd_end_q   <= '0;
      was_set_q  <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      interval_q <= interval_d;
      count_q    <= count_d;
      loop_q     <= loop_d;
      cooldown_q <= cooldown_d;
      mode_q     <= mode_d;
      idx_q      <= idx_d;
      acc_q      <= acc_d;
      cd_end_q   <= cd_end_d;
      was_set_q  <= was_set_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    sel_q    <= sel_d;
    now_q    <= now_d;
    delta_q  <= delta_d;
    err_q    <= err_d;
    ofr_q    <= ofr_d;
    ostate_q <= ostate_d;
    oerr_q   <= oerr_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = ofr_q;
  assign m_axis_tuser  = {oerr_q, ostate_q};
  assign cfg_ready     = 1'b1;

endmodule

>>> rtl/core/fas_div.sv
// Restoring divider that retires one quotient bit per cycle.
module fas_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fas_pkg::div_req_t req_i,
  output fas_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [fas_pkg::STEP_BITS-1:0]     cnt_q, cnt_d;
  logic [fas_pkg::TIME_BITS-1:0]     dvd_q, dvd_d;
  logic [fas_pkg::TIME_BITS-1:0]     quo_q, quo_d;
  logic [fas_pkg::INTERVAL_BITS-1:0] rem_q, rem_d;
  logic [fas_pkg::INTERVAL_BITS-1:0] dvs_q, dvs_d;
  logic [fas_pkg::INTERVAL_BITS:0]   trial;
  logic [fas_pkg::INTERVAL_BITS:0]   diff;
  logic                              fits;

  assign trial = {rem_q, dvd_q[fas_pkg::TIME_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[fas_pkg::TIME_BITS-2:0], 1'b0};
      quo_d = {quo_q[fas_pkg::TIME_BITS-2:0], fits};
      rem_d = fits ? diff[fas_pkg::INTERVAL_BITS-1:0] : trial[fas_pkg::INTERVAL_BITS-1:0];
      cnt_d = cnt_q - fas_pkg::STEP_BITS'(1);
      if (cnt_q == fas_pkg::STEP_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/core/fas_checker.sv
// Port-level checker of the frame animation sequencer and its bind.
`include "assert_macros.svh"

module fas_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result keeps its payload.
  `FAS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  // A request keeps the block busy for at least the following cycle.
  `FAS_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")
  // A new result only appears after the block was busy and could take no request.
  `FAS_ASSERT(a_result_from_busy, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result without work")

endmodule

bind frame_animation_sequencer fas_checker u_fas_checker (.*);

>>> verif/anim_result_checker.sv
`timescale 1ns / 1ps
// Checker that follows the sequencer's requests and results and compares each result.
module anim_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [7:0]     frame;
    fas_pkg::mode_e mode;
    logic           err;
  } anim_result_t;

  logic [15:0]  cfg_interval = 16'd100;
  logic [8:0]   cfg_count    = 9'd1;
  logic         cfg_loop     = 1'b1;
  logic [15:0]  cfg_cooldown = 16'd0;

  fas_pkg::mode_e anim_mode  = fas_pkg::MODE_PAUSED;
  logic [7:0]   frame_idx    = '0;
  logic [31:0]  accum_ms     = '0;
  logic [31:0]  cooldown_end = '0;
  logic         frame_set    = 1'b0;

  anim_result_t awaited_results[$];
  anim_result_t want;
  anim_result_t predicted;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic logic [8:0] frames_in_use();
    logic [8:0] c;
    c = cfg_count;
    if (c == '0) c = 9'd1;
    if (c > fas_pkg::CNT_LIMIT) c = fas_pkg::CNT_LIMIT;
    return c;
  endfunction

  function automatic void resume_play();
    if (anim_mode == fas_pkg::MODE_PLAYING) return;
    if (anim_mode == fas_pkg::MODE_ENDED || anim_mode == fas_pkg::MODE_COOLDOWN) begin
      if (!frame_set) frame_idx = '0;
      frame_set = 1'b0;
    end
    anim_mode = fas_pkg::MODE_PLAYING;
  endfunction

  function automatic anim_result_t advance_sequencer(input fas_pkg::req_type_e req,
                                                     input logic [7:0] sel,
                                                     input logic [31:0] now,
                                                     input logic [15:0] delta);
    anim_result_t r;
    logic [32:0]  sum;
    logic [31:0]  steps;
    logic [8:0]   cnt;
    logic [15:0]  iv;
    r.err = 1'b0;
    cnt = frames_in_use();
    iv = (cfg_interval == '0) ? 16'd1 : cfg_interval;
    case (req)
      fas_pkg::REQ_TICK: begin
        if (anim_mode == fas_pkg::MODE_COOLDOWN) begin
          if (now >= cooldown_end) resume_play();
        end else if (anim_mode == fas_pkg::MODE_PLAYING) begin
          sum = {1'b0, accum_ms} + 33'(delta);
          accum_ms = sum[32] ? fas_pkg::TIME_MAX : sum[31:0];
          steps = accum_ms / 32'(iv);
          if (steps != '0) begin
            accum_ms = '0;
            if (9'(frame_idx) < cnt && steps < 32'(cnt) - 32'(frame_idx)) begin
              frame_idx = frame_idx + 8'(steps);
            end else if (cfg_loop) begin
              sum = {1'b0, now} + 33'(cfg_cooldown);
              cooldown_end = sum[32] ? fas_pkg::TIME_MAX : sum[31:0];
              anim_mode = fas_pkg::MODE_COOLDOWN;
              frame_idx = 8'((32'(frame_idx) + steps % 32'(cnt)) % 32'(cnt));
            end else begin
              anim_mode = fas_pkg::MODE_ENDED;
              frame_idx = 8'(cnt - 9'd1);
            end
          end
        end
      end
      fas_pkg::REQ_PLAY: resume_play();
      fas_pkg::REQ_PAUSE: begin
        if (anim_mode == fas_pkg::MODE_PLAYING || anim_mode == fas_pkg::MODE_COOLDOWN) begin
          anim_mode = fas_pkg::MODE_PAUSED;
        end
      end
      default: begin
        if (9'(sel) >= cnt) begin
          r.err = 1'b1;
        end else begin
          frame_idx = sel;
          if (anim_mode == fas_pkg::MODE_ENDED || anim_mode == fas_pkg::MODE_COOLDOWN) begin
            frame_set = 1'b1;
          end
        end
      end
    endcase
    r.frame = frame_idx;
    r.mode  = anim_mode;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_interval = 16'd100;
      cfg_count    = 9'd1;
      cfg_loop     = 1'b1;
      cfg_cooldown = 16'd0;
      anim_mode    = fas_pkg::MODE_PAUSED;
      frame_idx    = '0;
      accum_ms     = '0;
      cooldown_end = '0;
      frame_set    = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: current_frame %0d, anim_state %0d, frame_error %0d",
                 m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2]);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = awaited_results.pop_front();
          checked_o = checked_o + 1;
          if (m_axis_tdata !== want.frame) begin
            $error("current_frame: expected %0d, actual %0d", want.frame, m_axis_tdata);
            fail_count_o = fail_count_o + 1;
          end
          if (m_axis_tuser[1:0] !== want.mode) begin
            $error("anim_state: expected %0d, actual %0d", want.mode, m_axis_tuser[1:0]);
            fail_count_o = fail_count_o + 1;
          end
          if (m_axis_tuser[2] !== want.err) begin
            $error("frame_error: expected %0d, actual %0d", want.err, m_axis_tuser[2]);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (fas_pkg::cfg_idx_e'(cfg_addr))
          fas_pkg::CFG_INTERVAL: cfg_interval = cfg_data;
          fas_pkg::CFG_COUNT:    cfg_count    = cfg_data[8:0];
          fas_pkg::CFG_LOOP:     cfg_loop     = cfg_data[0];
          default:               cfg_cooldown = cfg_data;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = advance_sequencer(fas_pkg::req_type_e'(s_axis_tuser),
                                      s_axis_tdata[7:0],
                                      s_axis_tdata[39:8],
                                      s_axis_tdata[55:40]);
        awaited_results.insert(awaited_results.size(), predicted);
      end
    end
    pending_o = awaited_results.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the frame animation sequencer: clock, reset, stimulus and verdict.
module testbench;

  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr      = '0;
  logic [15:0] cfg_data      = '0;

  int fail_count;
  int pending;
  int checked;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int hold_reqs       = 0;
  int holds_done      = 0;
  int hold_left       = 0;
  int cycles          = 0;
  int settings_used   = 0;
  int reg_writes      = 0;
  int req_seen[4]     = '{0, 0, 0, 0};

  logic [31:0] clock_ms     = 32'd1000;
  logic [15:0] cur_interval = 16'd100;
  logic [8:0]  cur_count    = 9'd1;

  frame_animation_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  anim_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("frame_animation_sequencer verification failed");
      $finish;
    end
  end

  // The output side stalls at random, or holds off for a long stretch on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_reqs) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_request(input fas_pkg::req_type_e req, input logic [7:0] sel,
                              input logic [31:0] now, input logic [15:0] delta);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {delta, now, sel};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    req_seen[req] = req_seen[req] + 1;
  endtask

  task automatic push_tick(input logic [15:0] delta);
    clock_ms = clock_ms + 32'(delta);
    push_request(fas_pkg::REQ_TICK, 8'($urandom), clock_ms, delta);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input fas_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    reg_writes = reg_writes + 1;
  endtask

  task automatic apply_setting(input logic [15:0] interval, input logic [8:0] count,
                               input logic loop_en, input logic [15:0] cooldown);
    wait_idle();
    write_reg(fas_pkg::CFG_INTERVAL, interval);
    write_reg(fas_pkg::CFG_COUNT, 16'(count));
    write_reg(fas_pkg::CFG_LOOP, {15'd0, loop_en});
    write_reg(fas_pkg::CFG_COOLDOWN, cooldown);
    cfg_valid <= 1'b0;
    cur_interval = interval;
    cur_count = count;
    settings_used = settings_used + 1;
  endtask

  task automatic random_request();
    int          pick;
    int unsigned span;
    logic [7:0]  sel_top;
    logic [15:0] delta;
    pick = $urandom_range(99);
    span = (cur_interval == '0) ? 2 : 2 * cur_interval;
    if (span > 65535) span = 65535;
    if (cur_count == '0) sel_top = 8'd0;
    else if (cur_count > 9'd256) sel_top = 8'd255;
    else sel_top = 8'(cur_count - 9'd1);
    if (pick < 70) begin
      case ($urandom_range(9))
        0:       delta = 16'd0;
        1:       delta = 16'($urandom);
        default: delta = 16'($urandom_range(0, span));
      endcase
      push_tick(delta);
    end else if (pick < 80) begin
      push_request(fas_pkg::REQ_PLAY, 8'($urandom), clock_ms, 16'($urandom));
    end else if (pick < 86) begin
      push_request(fas_pkg::REQ_PAUSE, 8'($urandom), clock_ms, 16'($urandom));
    end else if (pick < 96) begin
      if ($urandom_range(3) == 0) begin
        push_request(fas_pkg::REQ_SET, 8'($urandom), clock_ms, 16'($urandom));
      end else begin
        push_request(fas_pkg::REQ_SET, 8'($urandom_range(0, sel_top)), clock_ms,
                     16'($urandom));
      end
    end else begin
      push_request(fas_pkg::req_type_e'($urandom_range(3)), 8'($urandom), $urandom,
                   16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] interval;
    logic [8:0]  count;
    logic [15:0] cooldown;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_tick(16'hFFFF);
    push_request(fas_pkg::REQ_SET, 8'd0, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_SET, 8'd255, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);
    push_tick(16'd50);
    push_tick(16'd60);
    push_tick(16'd0);
    push_request(fas_pkg::REQ_PAUSE, 8'd0, clock_ms, 16'd0);

    apply_setting(16'd0, 9'd300, 1'b0, 16'hFFFF);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);
    push_tick(16'hFFFF);
    push_tick(16'd5);
    push_request(fas_pkg::REQ_PAUSE, 8'd0, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_SET, 8'd10, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);
    push_tick(16'd100);

    apply_setting(16'hFFFF, 9'd256, 1'b1, 16'hFFFF);
    push_request(fas_pkg::REQ_SET, 8'd255, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_TICK, 8'd0, 32'hFFFF_FFF0, 16'hFFFF);
    push_request(fas_pkg::REQ_TICK, 8'd0, 32'hFFFF_FFFE, 16'd0);
    push_request(fas_pkg::REQ_SET, 8'd7, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_TICK, 8'd0, 32'hFFFF_FFFF, 16'd0);

    // A lowered frame count leaves the index past the end until the next advance.
    apply_setting(16'd1, 9'd0, 1'b1, 16'd0);
    push_tick(16'd3);
    push_request(fas_pkg::REQ_PAUSE, 8'd0, clock_ms, 16'd0);
    apply_setting(16'd1, 9'd511, 1'b1, 16'd0);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);
    push_request(fas_pkg::REQ_SET, 8'd200, clock_ms, 16'd0);
    apply_setting(16'd1, 9'd5, 1'b1, 16'd0);
    push_tick(16'd7);
    push_request(fas_pkg::REQ_PLAY, 8'd0, clock_ms, 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(5))
        0:       interval = 16'd1;
        1:       interval = 16'hFFFF;
        2:       interval = 16'd0;
        3:       interval = 16'($urandom);
        default: interval = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(6))
        0:       count = 9'd1;
        1:       count = 9'd256;
        2:       count = 9'd0;
        3:       count = 9'($urandom_range(257, 511));
        4:       count = 9'($urandom_range(1, 256));
        default: count = 9'($urandom_range(2, 16));
      endcase
      case ($urandom_range(3))
        0:       cooldown = 16'd0;
        1:       cooldown = 16'hFFFF;
        2:       cooldown = 16'($urandom);
        default: cooldown = 16'($urandom_range(0, 400));
      endcase
      apply_setting(interval, count, 1'($urandom), cooldown);
      if ($urandom_range(2) == 0) clock_ms = $urandom;
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 62;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 62;
        end
        default: begin
          sender_idle_pct = 11;
          sink_stall_pct  = 11;
        end
      endcase
      push_request(fas_pkg::REQ_PLAY, 8'($urandom), clock_ms, 16'($urandom));
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (i == RANDOM_ITEMS / (2 * PHASES) && (p == 2 || p == 5)) hold_reqs = hold_reqs + 1;
        random_request();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d ticks, %0d play, %0d pause and %0d set-frame requests; %0d checked.",
             req_seen[fas_pkg::REQ_TICK], req_seen[fas_pkg::REQ_PLAY],
             req_seen[fas_pkg::REQ_PAUSE], req_seen[fas_pkg::REQ_SET], checked);
    $display("Used %0d register settings (%0d writes), four idle patterns, %0d long output holds.",
             settings_used, reg_writes, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("frame_animation_sequencer verification clean");
    end else begin
      $display("frame_animation_sequencer verification failed");
    end
    $finish;
  end

endmodule
